@@ src/assert_macros.svh @@
// Assertion macros shared by the steer and throttle command block.
// Expects clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stc: property violated");
`define STC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("stc: forbidden condition");
`else
`define STC_ASSERT(lbl, prop)
`define STC_ASSERT_NEVER(lbl, expr)
`endif
`endif

@@ src/stc_pkg.sv @@
// Types, constants and tables for the steer and throttle command block.
// No dependencies.
package stc_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ITER_W = $clog2(CORDIC_ITERATIONS);

  localparam logic [11:0] STOP_THROTTLE = 12'd1500;
  localparam logic signed [31:0] PI_Q28 = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [32:0] CORDIC_K_Q30 = 33'sd652032874;
  localparam logic signed [24:0] DEG_PER_RAD_Q16 = 25'sd3754936;

  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_TARGET_SPEED = 3'd0;
  localparam logic [2:0] REG_GAS_GAIN = 3'd1;
  localparam logic [2:0] REG_BASE_SPEED = 3'd2;
  localparam logic [2:0] REG_BASE_ANGLE = 3'd3;
  localparam logic [2:0] REG_ANGLE_GAIN = 3'd4;
  localparam logic [2:0] REG_LOOKAHEAD = 3'd5;
  localparam logic [2:0] REG_WHEELBASE = 3'd6;
  localparam logic [2:0] REG_ANCHOR_OFFSET = 3'd7;

  typedef struct packed {
    logic signed [15:0] target_speed;
    logic signed [15:0] speed_gain;
    logic [11:0] base_speed;
    logic signed [15:0] base_angle;
    logic signed [15:0] steer_gain;
    logic [14:0] lookahead;
    logic [14:0] wheelbase;
    logic [14:0] anchor_offset;
  } stc_cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_ROT, OP_FLIP, OP_MNUM, OP_MDEN, OP_DEN, OP_VPRE,
    OP_VEC, OP_MDEG, OP_RND, OP_MGAIN, OP_STEER, OP_ERR, OP_INC, OP_THR
  } stc_op_t;

  typedef struct packed {
    stc_op_t op;
    logic [ITER_W-1:0] iter;
    logic load_out;
  } stc_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_FLIP, S_MNUM, S_MDEN, S_DEN, S_VPRE, S_VEC, S_MDEG,
    S_RND, S_MGAIN, S_STEER, S_ERR, S_INC, S_THR, S_DONE
  } stc_state_t;

  function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0: v = 32'sd210828714;
      5'd1: v = 32'sd124459457;
      5'd2: v = 32'sd65760959;
      5'd3: v = 32'sd33381290;
      5'd4: v = 32'sd16755422;
      5'd5: v = 32'sd8385879;
      5'd6: v = 32'sd4193963;
      5'd7: v = 32'sd2097109;
      5'd8: v = 32'sd1048571;
      5'd9: v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/stc_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing.
interface stc_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] measured_speed;
  logic signed [15:0] heading_error;
  logic steer_valid;
  logic drive_enable;
  modport source (output valid, measured_speed, heading_error, steer_valid, drive_enable,
                  input ready);
  modport sink (input valid, measured_speed, heading_error, steer_valid, drive_enable,
                output ready);
endinterface

interface stc_out_if;
  logic valid;
  logic ready;
  logic [11:0] throttle_cmd;
  logic signed [15:0] steering_cmd;
  modport source (output valid, throttle_cmd, steering_cmd, input ready);
  modport sink (input valid, throttle_cmd, steering_cmd, output ready);
endinterface

@@ src/steer_and_throttle_command.sv @@
// Top level of the steer and throttle command block.
// Depends on stc_pkg, stc_if, stc_regs, stc_ctrl and stc_dp.
//
// Usage:
//   in_ch carries one control tick: measured_speed, heading_error,
//   steer_valid and drive_enable. out_ch returns one result per tick:
//   throttle_cmd and steering_cmd.
//   Registers are written over the APB port at byte address 4*index. The user
//   must write them only while no item is in flight; the block does not enforce it.
// Flow:
//   The time from acceptance to result valid is set by the CORDIC rotation
//   and vectoring passes through the shared iteration counter and arctangent
//   table. One item is in work at a time; the next is taken in the cycle
//   after the previous result is in the output register, even if the
//   receiver has not taken it, so a new item is never taken before the
//   last one is through.
//   When the receiver stalls, the result holds and a finished item waits
//   in the last step until the output register frees.
// Reset:
//   rst clears the PID error history, the handshake state and the
//   registers to their defaults.
module steer_and_throttle_command (
  input  logic clk,
  input  logic rst,
  stc_in_if.sink in_ch,
  stc_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [stc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  stc_pkg::stc_cfg_t cfg;
  stc_pkg::stc_cmd_t cmd;

  stc_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  stc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd)
  );

  stc_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg(cfg),
    .measured_speed(in_ch.measured_speed), .heading_error(in_ch.heading_error),
    .steer_valid(in_ch.steer_valid), .drive_enable(in_ch.drive_enable),
    .throttle_cmd(out_ch.throttle_cmd), .steering_cmd(out_ch.steering_cmd)
  );

endmodule

@@ src/stc_regs.sv @@
// APB configuration registers of the steer and throttle command block.
// Depends on stc_pkg.
module stc_regs (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [stc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output stc_pkg::stc_cfg_t cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_speed <= 16'sd256;
      cfg.speed_gain <= 16'sd256;
      cfg.base_speed <= 12'd1470;
      cfg.base_angle <= 16'sd23040;
      cfg.steer_gain <= -16'sd256;
      cfg.lookahead <= 15'd128;
      cfg.wheelbase <= 15'd67;
      cfg.anchor_offset <= 15'd33;
    end else if (wr) begin
      case (paddr[4:2])
        stc_pkg::REG_TARGET_SPEED: cfg.target_speed <= pwdata[15:0];
        stc_pkg::REG_GAS_GAIN: cfg.speed_gain <= pwdata[15:0];
        stc_pkg::REG_BASE_SPEED: cfg.base_speed <= pwdata[11:0];
        stc_pkg::REG_BASE_ANGLE: cfg.base_angle <= pwdata[15:0];
        stc_pkg::REG_ANGLE_GAIN: cfg.steer_gain <= pwdata[15:0];
        stc_pkg::REG_LOOKAHEAD: cfg.lookahead <= pwdata[14:0];
        stc_pkg::REG_WHEELBASE: cfg.wheelbase <= pwdata[14:0];
        stc_pkg::REG_ANCHOR_OFFSET: cfg.anchor_offset <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      stc_pkg::REG_TARGET_SPEED: prdata = {16'd0, cfg.target_speed};
      stc_pkg::REG_GAS_GAIN: prdata = {16'd0, cfg.speed_gain};
      stc_pkg::REG_BASE_SPEED: prdata = {20'd0, cfg.base_speed};
      stc_pkg::REG_BASE_ANGLE: prdata = {16'd0, cfg.base_angle};
      stc_pkg::REG_ANGLE_GAIN: prdata = {16'd0, cfg.steer_gain};
      stc_pkg::REG_LOOKAHEAD: prdata = {17'd0, cfg.lookahead};
      stc_pkg::REG_WHEELBASE: prdata = {17'd0, cfg.wheelbase};
      stc_pkg::REG_ANCHOR_OFFSET: prdata = {17'd0, cfg.anchor_offset};
      default: prdata = 32'd0;
    endcase
  end

endmodule

@@ src/stc_dp.sv @@
// Datapath: CORDIC rotation and vectoring, shared multiplier, PID state
// and result registers. Depends on stc_pkg.
module stc_dp (
  input  logic clk,
  input  logic rst,
  input  stc_pkg::stc_cmd_t cmd,
  input  stc_pkg::stc_cfg_t cfg,
  input  logic signed [15:0] measured_speed,
  input  logic signed [15:0] heading_error,
  input  logic steer_valid,
  input  logic drive_enable,
  output logic [11:0] throttle_cmd,
  output logic signed [15:0] steering_cmd
);

  logic signed [15:0] speed;
  logic valid_q, drive_q, flip, zero;
  logic signed [31:0] z, vz, at, zin;
  logic signed [32:0] rx, ry, rxs, rys;
  logic signed [47:0] num;
  logic signed [49:0] vx, vy, vxs, vys;
  logic signed [32:0] ma;
  logic signed [24:0] mb;
  logic signed [57:0] prod, r28, r16, r8;
  logic signed [24:0] d;
  logic signed [25:0] ssum, ev;
  logic signed [15:0] steer;
  logic signed [23:0] e, last_error, older_error;
  logic signed [30:0] inc, inc_next, ir31;
  logic signed [24:0] tv;
  logic [11:0] thr;
  logic signed [16:0] diff;
  logic signed [47:0] den;

  assign at = stc_pkg::atan_q28(5'(cmd.iter));
  assign rxs = rx >>> cmd.iter;
  assign rys = ry >>> cmd.iter;
  assign vxs = vx >>> cmd.iter;
  assign vys = vy >>> cmd.iter;
  assign zin = signed'({heading_error[15], heading_error, 15'd0});
  assign diff = 17'(cfg.target_speed) - 17'(speed);
  assign den = signed'(48'({cfg.lookahead, 29'd0})) + prod[47:0];
  assign r28 = prod + 58'sd134217728;
  assign r16 = prod + 58'sd32768;
  assign r8 = prod + 58'sd128;
  assign ssum = 26'(cfg.base_angle) + 26'(r16 >>> 16);
  assign ev = 26'(r8 >>> 8);
  assign inc_next = (31'(e) <<< 4) + (31'(e) <<< 3) + (31'(e) <<< 1) + 31'(e)
                  - (31'(last_error) <<< 4) - (31'(last_error) <<< 3)
                  + (31'(older_error) <<< 1);
  assign ir31 = (inc + 31'sd128) >>> 8;
  assign tv = signed'({13'd0, cfg.base_speed}) - 25'(ir31);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      stc_pkg::OP_MNUM: begin
        ma = ry;
        mb = signed'({10'd0, cfg.wheelbase});
      end
      stc_pkg::OP_MDEN: begin
        ma = rx;
        mb = signed'({10'd0, cfg.anchor_offset});
      end
      stc_pkg::OP_MDEG: begin
        ma = zero ? 33'sd0 : 33'(vz);
        mb = stc_pkg::DEG_PER_RAD_Q16;
      end
      stc_pkg::OP_MGAIN: begin
        ma = 33'(d);
        mb = 25'(cfg.steer_gain);
      end
      stc_pkg::OP_STEER: begin
        ma = 33'(diff);
        mb = 25'(cfg.speed_gain);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      older_error <= '0;
    end else if (cmd.op == stc_pkg::OP_THR && valid_q && drive_q) begin
      older_error <= last_error;
      last_error <= e;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (cmd.op)
      stc_pkg::OP_LOAD: begin
        speed <= measured_speed;
        valid_q <= steer_valid;
        drive_q <= drive_enable;
        rx <= stc_pkg::CORDIC_K_Q30;
        ry <= '0;
        if (zin > stc_pkg::HALF_PI_Q28) begin
          z <= zin - stc_pkg::PI_Q28;
          flip <= 1'b1;
        end else if (zin < -stc_pkg::HALF_PI_Q28) begin
          z <= zin + stc_pkg::PI_Q28;
          flip <= 1'b1;
        end else begin
          z <= zin;
          flip <= 1'b0;
        end
      end
      stc_pkg::OP_ROT: begin
        if (z >= 0) begin
          rx <= rx - rys;
          ry <= ry + rxs;
          z <= z - at;
        end else begin
          rx <= rx + rys;
          ry <= ry - rxs;
          z <= z + at;
        end
      end
      stc_pkg::OP_FLIP: begin
        if (flip) begin
          rx <= -rx;
          ry <= -ry;
        end
      end
      stc_pkg::OP_MDEN: num <= prod[47:0];
      stc_pkg::OP_DEN: begin
        vx <= 50'(den);
        vy <= 50'(num);
      end
      stc_pkg::OP_VPRE: begin
        zero <= (vy == 0) && (vx >= 0);
        if (vx < 0) begin
          if (vy >= 0) begin
            vx <= vy;
            vy <= -vx;
            vz <= stc_pkg::HALF_PI_Q28;
          end else begin
            vx <= -vy;
            vy <= vx;
            vz <= -stc_pkg::HALF_PI_Q28;
          end
        end else begin
          vz <= '0;
        end
      end
      stc_pkg::OP_VEC: begin
        if (vy > 0) begin
          vx <= vx + vys;
          vy <= vy - vxs;
          vz <= vz + at;
        end else begin
          vx <= vx - vys;
          vy <= vy + vxs;
          vz <= vz - at;
        end
      end
      stc_pkg::OP_RND: d <= -25'(r28 >>> 28);
      stc_pkg::OP_STEER: begin
        if (ssum > 26'sd32767) begin
          steer <= 16'sh7FFF;
        end else if (ssum < -26'sd32768) begin
          steer <= -16'sd32768;
        end else begin
          steer <= 16'(ssum);
        end
      end
      stc_pkg::OP_ERR: begin
        if (ev > 26'sd8388607) begin
          e <= 24'sh7FFFFF;
        end else if (ev < -26'sd8388608) begin
          e <= -24'sd8388608;
        end else begin
          e <= 24'(ev);
        end
      end
      stc_pkg::OP_INC: inc <= inc_next;
      stc_pkg::OP_THR: begin
        if (tv < 0) begin
          thr <= 12'd0;
        end else if (tv > 25'sd4095) begin
          thr <= 12'd4095;
        end else begin
          thr <= 12'(tv);
        end
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      throttle_cmd <= (valid_q && drive_q) ? thr : stc_pkg::STOP_THROTTLE;
      steering_cmd <= valid_q ? steer : cfg.base_angle;
    end
  end

endmodule

@@ src/stc_ctrl.sv @@
// Controller: sequences the datapath over one item and owns the channel
// handshakes. Depends on stc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module stc_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output stc_pkg::stc_cmd_t cmd
);

  localparam logic [stc_pkg::ITER_W-1:0] LAST =
    stc_pkg::ITER_W'(stc_pkg::CORDIC_ITERATIONS - 1);

  stc_pkg::stc_state_t state, state_next;
  logic [stc_pkg::ITER_W-1:0] cnt, cnt_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stc_pkg::S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    out_valid_next = out_valid && !out_ready;
    in_ready = 1'b0;
    cmd.op = stc_pkg::OP_NONE;
    cmd.iter = cnt;
    cmd.load_out = 1'b0;
    case (state)
      stc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = stc_pkg::OP_LOAD;
          cnt_next = '0;
          state_next = stc_pkg::S_ROT;
        end
      end
      stc_pkg::S_ROT: begin
        cmd.op = stc_pkg::OP_ROT;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) begin
          cnt_next = '0;
          state_next = stc_pkg::S_FLIP;
        end
      end
      stc_pkg::S_FLIP: begin
        cmd.op = stc_pkg::OP_FLIP;
        state_next = stc_pkg::S_MNUM;
      end
      stc_pkg::S_MNUM: begin
        cmd.op = stc_pkg::OP_MNUM;
        state_next = stc_pkg::S_MDEN;
      end
      stc_pkg::S_MDEN: begin
        cmd.op = stc_pkg::OP_MDEN;
        state_next = stc_pkg::S_DEN;
      end
      stc_pkg::S_DEN: begin
        cmd.op = stc_pkg::OP_DEN;
        state_next = stc_pkg::S_VPRE;
      end
      stc_pkg::S_VPRE: begin
        cmd.op = stc_pkg::OP_VPRE;
        state_next = stc_pkg::S_VEC;
      end
      stc_pkg::S_VEC: begin
        cmd.op = stc_pkg::OP_VEC;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) begin
          cnt_next = '0;
          state_next = stc_pkg::S_MDEG;
        end
      end
      stc_pkg::S_MDEG: begin
        cmd.op = stc_pkg::OP_MDEG;
        state_next = stc_pkg::S_RND;
      end
      stc_pkg::S_RND: begin
        cmd.op = stc_pkg::OP_RND;
        state_next = stc_pkg::S_MGAIN;
      end
      stc_pkg::S_MGAIN: begin
        cmd.op = stc_pkg::OP_MGAIN;
        state_next = stc_pkg::S_STEER;
      end
      stc_pkg::S_STEER: begin
        cmd.op = stc_pkg::OP_STEER;
        state_next = stc_pkg::S_ERR;
      end
      stc_pkg::S_ERR: begin
        cmd.op = stc_pkg::OP_ERR;
        state_next = stc_pkg::S_INC;
      end
      stc_pkg::S_INC: begin
        cmd.op = stc_pkg::OP_INC;
        state_next = stc_pkg::S_THR;
      end
      stc_pkg::S_THR: begin
        cmd.op = stc_pkg::OP_THR;
        state_next = stc_pkg::S_DONE;
      end
      stc_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          out_valid_next = 1'b1;
          state_next = stc_pkg::S_IDLE;
        end
      end
      default: state_next = stc_pkg::S_IDLE;
    endcase
  end

  `STC_ASSERT(a_accept_starts, in_valid && in_ready |=> state == stc_pkg::S_ROT)
  `STC_ASSERT(a_result_from_done, $rose(out_valid) |-> $past(state == stc_pkg::S_DONE))
  `STC_ASSERT(a_vec_exit, state == stc_pkg::S_VEC && cnt == LAST |=> state == stc_pkg::S_MDEG)

endmodule
